@@ sv/line_edit_buffer_macros.svh @@
// Assertion macros for the line edit buffer.
// Used by the top level; no other dependency.
`ifndef LINE_EDIT_BUFFER_MACROS_SVH
`define LINE_EDIT_BUFFER_MACROS_SVH
`ifndef ASSERT_OFF
`define LEB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("check failed");
`define LEB_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`else
`define LEB_ASSERT(lbl, prop)
`define LEB_ASSERT_MSG(lbl, prop, msg)
`endif
`endif

@@ sv/leb_pkg.sv @@
// Package for the line edit buffer: command codes, beat structs,
// controller states and the controller/datapath link structs.
`default_nettype none

package leb_pkg;

  localparam int CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [2:0] {
    CMD_BACKSPACE = 3'd0,
    CMD_DELETE    = 3'd1,
    CMD_LEFT      = 3'd2,
    CMD_RIGHT     = 3'd3,
    CMD_INSERT    = 3'd4,
    CMD_READ      = 3'd5
  } leb_cmd_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] symbol;
    logic [7:0] index;
  } leb_in_t;

  typedef struct packed {
    logic [8:0] cursor_pos;
    logic [8:0] fill_count;
    logic [7:0] read_byte;
    logic       applied;
  } leb_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_L,
    ST_SHIFT_R,
    ST_RD_WAIT,
    ST_DONE
  } leb_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic setup_l;
    logic setup_r;
    logic shift_l;
    logic shift_r;
    logic mv_left;
    logic mv_right;
    logic commit_del;
    logic commit_ins;
    logic rd_issue;
    logic rd_capture;
    logic emit;
  } leb_ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic [2:0] cmd;
    logic       cur_zero;
    logic       cur_at_end;
    logic       can_ins;
    logic       shift_l_done;
    logic       shift_r_done;
  } leb_st_t;

endpackage

`default_nettype wire

@@ sv/leb_ctrl.sv @@
// Controller state machine for the line edit buffer.
// Depends on leb_pkg for states and the link structs.
`default_nettype none

module leb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  output logic                  out_valid,
  input  wire leb_pkg::leb_st_t st,
  output leb_pkg::leb_ctl_t     ctl
);

  leb_pkg::leb_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= leb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctl           = '0;
    out_valid_nxt = 1'b0;
    case (state_r)
      leb_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load  = 1'b1;
          state_nxt = leb_pkg::ST_DECODE;
        end
      end
      leb_pkg::ST_DECODE: begin
        state_nxt = leb_pkg::ST_DONE;
        case (st.cmd)
          leb_pkg::CMD_BACKSPACE: begin
            if (!st.cur_zero) begin
              ctl.setup_l = 1'b1;
              state_nxt   = leb_pkg::ST_SHIFT_L;
            end
          end
          leb_pkg::CMD_DELETE: begin
            if (!st.cur_at_end) begin
              ctl.setup_l = 1'b1;
              state_nxt   = leb_pkg::ST_SHIFT_L;
            end
          end
          leb_pkg::CMD_LEFT:  ctl.mv_left  = !st.cur_zero;
          leb_pkg::CMD_RIGHT: ctl.mv_right = !st.cur_at_end;
          leb_pkg::CMD_INSERT: begin
            if (st.can_ins) begin
              ctl.setup_r = 1'b1;
              state_nxt   = leb_pkg::ST_SHIFT_R;
            end
          end
          leb_pkg::CMD_READ: begin
            ctl.rd_issue = 1'b1;
            state_nxt    = leb_pkg::ST_RD_WAIT;
          end
          default: state_nxt = leb_pkg::ST_DONE;
        endcase
      end
      leb_pkg::ST_SHIFT_L: begin
        ctl.shift_l = 1'b1;
        if (st.shift_l_done) begin
          ctl.commit_del = 1'b1;
          state_nxt      = leb_pkg::ST_DONE;
        end
      end
      leb_pkg::ST_SHIFT_R: begin
        ctl.shift_r = 1'b1;
        // The symbol goes in once the tail has moved and the write port is free.
        if (st.shift_r_done) begin
          ctl.commit_ins = 1'b1;
          state_nxt      = leb_pkg::ST_DONE;
        end
      end
      leb_pkg::ST_RD_WAIT: begin
        ctl.rd_capture = 1'b1;
        state_nxt      = leb_pkg::ST_DONE;
      end
      leb_pkg::ST_DONE: begin
        ctl.emit      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = leb_pkg::ST_IDLE;
      end
      default: state_nxt = leb_pkg::ST_IDLE;
    endcase
  end

  assign busy      = (state_r != leb_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ sv/leb_dp.sv @@
// Datapath for the line edit buffer: line memory, fill, cursor,
// capacity register and the shift pointer. Depends on leb_pkg.
`default_nettype none

module leb_dp #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire leb_pkg::leb_in_t            in_data,
  input  wire logic                        cfg_we,
  input  wire logic [leb_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire leb_pkg::leb_ctl_t           ctl,
  output leb_pkg::leb_st_t                 st,
  output leb_pkg::leb_out_t                out_data
);

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CW = $clog2(BUFFER_DEPTH + 1);
  localparam int KW = (CW > leb_pkg::CAP_W) ? CW : leb_pkg::CAP_W;
  localparam int IW = (AW > 8) ? AW : 8;
  localparam int XW = (IW > CW) ? IW : CW;
  localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  logic [7:0] mem [BUFFER_DEPTH];

  logic [CW-1:0]              fill_r, fill_nxt;
  logic [CW-1:0]              cursor_r, cursor_nxt;
  logic [leb_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic                       pend_r, pend_nxt;
  logic                       ok_r, ok_nxt;
  logic [CW-1:0]              src_r, src_nxt;
  logic [AW-1:0]              waddr_r, waddr_nxt;
  logic [2:0]                 cmd_r, cmd_nxt;
  logic [7:0]                 sym_r, sym_nxt;
  logic [7:0]                 idx_r, idx_nxt;
  logic [7:0]                 rbyte_r, rbyte_nxt;
  logic [7:0]                 mem_q_r;
  leb_pkg::leb_out_t          out_r, out_nxt;

  logic [CW-1:0] src_m1;
  logic [IW-1:0] idx_ext;
  logic          rd_en;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic          src_at_fill;
  logic          src_at_cursor;

  assign src_m1        = src_r - ONE_C;
  assign idx_ext       = IW'(idx_r);
  assign src_at_fill   = (src_r == fill_r);
  assign src_at_cursor = (src_r == cursor_r);

  // Memory port selection: one read and one write per cycle.
  always_comb begin
    rd_en = 1'b0;
    raddr = src_r[AW-1:0];
    if (ctl.shift_l && !src_at_fill) begin
      rd_en = 1'b1;
      raddr = src_r[AW-1:0];
    end else if (ctl.shift_r && !src_at_cursor) begin
      rd_en = 1'b1;
      raddr = src_m1[AW-1:0];
    end else if (ctl.rd_issue) begin
      rd_en = 1'b1;
      raddr = idx_ext[AW-1:0];
    end
    we    = pend_r || ctl.commit_ins;
    waddr = pend_r ? waddr_r : cursor_r[AW-1:0];
    wdata = pend_r ? mem_q_r : sym_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_comb begin
    fill_nxt   = fill_r;
    cursor_nxt = cursor_r;
    cap_nxt    = cfg_we ? cfg_wdata : cap_r;
    ok_nxt     = ok_r;
    src_nxt    = src_r;
    cmd_nxt    = cmd_r;
    sym_nxt    = sym_r;
    idx_nxt    = idx_r;
    rbyte_nxt  = rbyte_r;
    out_nxt    = out_r;
    // A byte read this cycle is written one place over in the next.
    pend_nxt   = rd_en && (ctl.shift_l || ctl.shift_r);
    waddr_nxt  = ctl.shift_l ? src_m1[AW-1:0] : src_r[AW-1:0];

    if (ctl.load) begin
      cmd_nxt   = in_data.command;
      sym_nxt   = in_data.symbol;
      idx_nxt   = in_data.index;
      ok_nxt    = 1'b0;
      rbyte_nxt = 8'd0;
    end
    if (ctl.setup_l) begin
      // Backspace closes the gap left of the cursor, delete the one at it.
      src_nxt = (cmd_r == leb_pkg::CMD_DELETE) ? cursor_r + ONE_C : cursor_r;
    end
    if (ctl.setup_r) begin
      src_nxt = fill_r;
    end
    if (ctl.shift_l && !src_at_fill) begin
      src_nxt = src_r + ONE_C;
    end
    if (ctl.shift_r && !src_at_cursor) begin
      src_nxt = src_m1;
    end
    if (ctl.mv_left) begin
      cursor_nxt = cursor_r - ONE_C;
      ok_nxt     = 1'b1;
    end
    if (ctl.mv_right) begin
      cursor_nxt = cursor_r + ONE_C;
      ok_nxt     = 1'b1;
    end
    if (ctl.commit_del) begin
      fill_nxt = fill_r - ONE_C;
      if (cmd_r == leb_pkg::CMD_BACKSPACE) begin
        cursor_nxt = cursor_r - ONE_C;
      end
      ok_nxt = 1'b1;
    end
    if (ctl.commit_ins) begin
      fill_nxt   = fill_r + ONE_C;
      cursor_nxt = cursor_r + ONE_C;
      ok_nxt     = 1'b1;
    end
    if (ctl.rd_issue) begin
      ok_nxt = 1'b1;
    end
    if (ctl.rd_capture) begin
      rbyte_nxt = (XW'(idx_r) < XW'(fill_r)) ? mem_q_r : 8'd0;
    end
    if (ctl.emit) begin
      out_nxt.cursor_pos = 9'(cursor_r);
      out_nxt.fill_count = 9'(fill_r);
      out_nxt.read_byte  = rbyte_r;
      out_nxt.applied    = ok_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cursor_r <= '0;
      cap_r    <= leb_pkg::CAP_RESET;
      pend_r   <= 1'b0;
      ok_r     <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      cursor_r <= cursor_nxt;
      cap_r    <= cap_nxt;
      pend_r   <= pend_nxt;
      ok_r     <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    waddr_r <= waddr_nxt;
    cmd_r   <= cmd_nxt;
    sym_r   <= sym_nxt;
    idx_r   <= idx_nxt;
    rbyte_r <= rbyte_nxt;
    out_r   <= out_nxt;
  end

  always_comb begin
    st.cmd          = cmd_r;
    st.cur_zero     = (cursor_r == '0);
    st.cur_at_end   = (cursor_r == fill_r);
    st.can_ins      = (KW'(fill_r) < KW'(cap_r)) && (fill_r != DEPTH_C);
    st.shift_l_done = src_at_fill && !pend_r;
    st.shift_r_done = src_at_cursor && !pend_r;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

@@ sv/line_edit_buffer.sv @@
// Line edit buffer top level: controller plus datapath.
// Depends on leb_pkg, leb_ctrl, leb_dp and line_edit_buffer_macros.svh.
//
//   Channel  | Ports                 | Handshake
//   ---------+-----------------------+-----------------------------------
//   input    | start, busy, in_data  | beat taken when start && !busy
//   result   | out_valid, out_data   | one-cycle strobe, no back-pressure
//   config   | cfg_we, cfg_wdata     | capacity written when cfg_we
//
// Left, right, refused and unknown commands pass through decode and done;
// read adds a wait state for the line memory. Backspace, delete and insert
// move the tail through the line memory one byte a cycle. busy drops in the
// strobe cycle, so the next beat may be taken there. Reset empties the line
// and sets capacity to 256.
`default_nettype none

`include "line_edit_buffer_macros.svh"

module line_edit_buffer #(
  parameter int BUFFER_DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire leb_pkg::leb_in_t           in_data,
  output logic                            out_valid,
  output leb_pkg::leb_out_t               out_data,
  input  wire logic                       cfg_we,
  input  wire logic [leb_pkg::CAP_W-1:0]  cfg_wdata
);

  leb_pkg::leb_ctl_t ctl;
  leb_pkg::leb_st_t  st;

  leb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .st        (st),
    .ctl       (ctl)
  );

  leb_dp #(
    .BUFFER_DEPTH (BUFFER_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .st        (st),
    .out_data  (out_data)
  );

  `LEB_ASSERT(a_decide_onehot, $onehot0({ctl.setup_l, ctl.setup_r, ctl.mv_left, ctl.mv_right, ctl.rd_issue}))
  `LEB_ASSERT_MSG(a_strobe_idle, out_valid |-> !busy, "result strobe while busy")
  `LEB_ASSERT_MSG(a_no_early_result, (start && !busy) |=> !out_valid, "result one cycle after accept")
  `LEB_ASSERT(a_commit_excl, !(ctl.commit_del && ctl.commit_ins))

endmodule

`default_nettype wire
